@@ src/sorted_ring_id_table_top_macros.svh @@
// assertion macros for the sorted ring id table checker
// used by the checker module only
`ifndef SORTED_RING_ID_TABLE_TOP_MACROS_SVH
`define SORTED_RING_ID_TABLE_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ src/srt_pkg.sv @@
// shared constants and types for the sorted ring id table
// no dependencies
package srt_pkg;
    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int IN_KEY_W      = 32;
    localparam int OUT_SLOT_W    = 8;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_NEAREST = 2'd1;
    localparam logic [1:0] OP_NEXT    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture op and key, clear scan
        logic rd;        // issue memory read at scan index
        logic scan_step; // compare read data, advance scan
        logic cand_rd;   // read candidate slot (sel 0/1)
        logic cand_sel;
        logic cand_cap;  // capture candidate data
        logic shift_rd;  // read entry to shift
        logic shift_wr;  // write shifted entry, step down
        logic ins_wr;    // write new key and bump count
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic empty;
        logic full;
    } t_stat;
endpackage

@@ src/srt_if.sv @@
// valid/ready channel interface carrying a payload struct
// depends on nothing
interface srt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/srt_dp.sv @@
// datapath: key memory, scan counter, candidate registers, result beat
// depends on srt_pkg
module srt_dp #(
    parameter int CAPACITY  = srt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = srt_pkg::KEY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srt_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_key,
    output srt_pkg::t_stat       o_stat,
    output logic [1:0]           o_status,
    output logic [31:0]          o_found_key,
    output logic [7:0]           o_found_slot
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KEY_WIDTH-1:0] KMAX = '1;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rdata;
    logic [CW-1:0] r_count, r_idx, r_sh;
    logic [1:0] r_op;
    logic [KEY_WIDTH-1:0] r_key, r_c0, r_c1;
    logic [AW-1:0] r_s0, r_s1;
    logic r_cap1;
    logic r_pe, r_pf;
    logic [AW-1:0] rd_addr;

    // candidate slots: scan index for the upper one, the slot below for the lower, both wrap
    logic [CW-1:0] n_s0, n_s1;
    always_comb begin
        n_s0 = r_idx;
        n_s1 = r_idx - CW'(1);
        if (r_idx == '0) begin
            n_s0 = '0;
            n_s1 = r_count - CW'(1);
        end else if (r_idx >= r_count) begin
            n_s0 = r_count - CW'(1);
            n_s1 = '0;
        end
    end

    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (i_cmd.cand_rd) rd_addr = i_cmd.cand_sel ? r_s1 : r_s0;
        else if (i_cmd.shift_rd) rd_addr = AW'(r_sh - CW'(1));
    end

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_wr) mem[r_sh[AW-1:0]] <= r_rdata;
        if (i_cmd.ins_wr)   mem[r_idx[AW-1:0]] <= r_key;
        r_rdata <= mem[rd_addr];
    end

    assign o_stat.scan_done  = (r_idx >= r_count) || (i_cmd.scan_step && r_rdata > r_key);
    assign o_stat.shift_done = (r_sh == r_idx);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count >= CW'(CAPACITY));

    // ring distance of each candidate (the wrap-around path is counted one short)
    function automatic logic [KEY_WIDTH-1:0] rdist(logic [KEY_WIDTH-1:0] a,
                                                  logic [KEY_WIDTH-1:0] b);
        logic [KEY_WIDTH-1:0] lo, hi, nv, ar;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        nv = hi - lo;
        ar = (KMAX - hi) + lo;
        return (nv < ar) ? nv : ar;
    endfunction

    logic pick0;
    logic [AW-1:0] sel;
    logic [KEY_WIDTH-1:0] selk;
    assign pick0 = rdist(r_key, r_c0) < rdist(r_key, r_c1);
    assign sel   = pick0 ? r_s0 : r_s1;
    assign selk  = pick0 ? r_c0 : r_c1;

    // result beat fields, judged on the table as it was when the beat came in
    always_comb begin
        o_status = srt_pkg::ST_OK; o_found_key = '0; o_found_slot = '0;
        case (r_op)
            srt_pkg::OP_INSERT: begin
                if (!r_pe && selk == r_key) begin
                    o_status = srt_pkg::ST_DUP;
                    o_found_slot = 8'(sel);
                end else if (r_pf) o_status = srt_pkg::ST_FULL;
                else o_found_slot = 8'(r_idx);
            end
            srt_pkg::OP_NEAREST, srt_pkg::OP_NEXT: begin
                if (r_pe) o_status = srt_pkg::ST_EMPTY;
                else if (r_op == srt_pkg::OP_NEAREST) begin
                    o_found_key = 32'(selk); o_found_slot = 8'(sel);
                end else begin
                    o_found_key = 32'(r_c0); o_found_slot = 8'(r_s0);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_wr) begin
            r_count <= r_count + CW'(1);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_key <= KEY_WIDTH'(i_key); r_idx <= '0;
            r_pe <= (r_count == '0);
            r_pf <= (r_count >= CW'(CAPACITY));
        end
        if (i_cmd.scan_step && !o_stat.scan_done) r_idx <= r_idx + CW'(1);
        if (i_cmd.scan_step && o_stat.scan_done) begin
            r_s0 <= AW'(r_op == srt_pkg::OP_NEXT ? n_s0 : n_s0);
            r_s1 <= AW'(n_s1);
            r_sh <= r_count;
        end
        if (i_cmd.cand_cap) begin
            if (r_cap1) r_c1 <= r_rdata; else r_c0 <= r_rdata;
        end
        if (i_cmd.cand_rd) r_cap1 <= i_cmd.cand_sel;
        if (i_cmd.shift_wr) r_sh <= r_sh - CW'(1);
    end
endmodule

@@ src/srt_ctrl.sv @@
// controller: sequences scan, candidate read, shift and insert
// depends on srt_pkg
module srt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic [1:0]     i_op,
    input  srt_pkg::t_stat i_stat,
    output srt_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CMP = 4'd2, S_C0 = 4'd3,
        S_C1 = 4'd4, S_C1W = 4'd5, S_DEC = 4'd6, S_SHR = 4'd7, S_SHW = 4'd8,
        S_INS = 4'd9, S_OUT = 4'd10, S_CW = 4'd11;
    logic [3:0] r_st, n_st;
    logic [1:0] r_op;
    logic r_ins;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);

    // next state and commands
    always_comb begin
        n_st = r_st; o_cmd = '0;
        case (r_st)
            S_IDLE: if (i_in_valid) begin o_cmd.load = 1'b1; n_st = S_RD; end
            S_RD: begin o_cmd.rd = 1'b1; n_st = S_CMP; end
            S_CMP: begin
                o_cmd.scan_step = 1'b1;
                n_st = i_stat.scan_done ? S_C0 : S_RD;
                if (i_stat.empty) n_st = (r_op == srt_pkg::OP_INSERT) ? S_DEC : S_OUT;
            end
            S_C0: begin o_cmd.cand_rd = 1'b1; n_st = S_CW; end
            S_CW: begin o_cmd.cand_cap = 1'b1; o_cmd.cand_rd = 1'b1;
                o_cmd.cand_sel = 1'b1; n_st = S_C1; end
            S_C1: begin o_cmd.cand_cap = 1'b1; n_st = S_C1W; end
            S_C1W: n_st = (r_op == srt_pkg::OP_INSERT) ? S_DEC : S_OUT;
            S_DEC: n_st = r_ins ? S_SHR : S_OUT;
            S_SHR: begin
                if (i_stat.shift_done) n_st = S_INS;
                else begin o_cmd.shift_rd = 1'b1; n_st = S_SHW; end
            end
            S_SHW: begin o_cmd.shift_wr = 1'b1; n_st = S_SHR; end
            S_INS: begin o_cmd.ins_wr = 1'b1; n_st = S_OUT; end
            S_OUT: if (i_out_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_op <= srt_pkg::OP_INSERT; r_ins <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_cmd.load) r_op <= i_op;
            // insert goes ahead unless duplicate or full; status known in S_DEC
            if (r_st == S_C1W || (r_st == S_CMP && i_stat.empty))
                r_ins <= (r_op == srt_pkg::OP_INSERT) && !i_stat.full;
            if (r_st == S_DEC && r_ins) r_ins <= r_ins;
        end
    end
endmodule

@@ src/sorted_ring_id_table_top.sv @@
// channel   | dir | payload
// in_ch     | in  | op[1:0], key[31:0]
// out_ch    | out | status[1:0], found_key[31:0], found_slot[7:0]
// one item at a time: a lookup reads and compares keys until the first key above the
// target, then reads two candidate slots; an empty table goes straight to the result
// insert adds a decision state, then a read and a write per key above it for shifting
// through the single memory port and the write when it goes ahead
// the controller returns to idle after each result beat; synchronous active-low reset empties the table
// result beat holds while out ready is low and nothing else moves
module sorted_ring_id_table_top #(
    parameter int CAPACITY  = srt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = srt_pkg::KEY_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srt_if.sink   in_ch,
    srt_if.source out_ch
);
    srt_pkg::t_cmd  cmd;
    srt_pkg::t_stat stat;
    logic [1:0]  status;
    logic [31:0] fkey;
    logic [7:0]  fslot;
    logic        dup_blk;

    srt_dp #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_op(in_ch.data.op), .i_key(in_ch.data.key),
        .o_stat(stat), .o_status(status), .o_found_key(fkey), .o_found_slot(fslot));

    // a duplicate blocks the insert: reported as full to controller decision
    srt_pkg::t_stat cstat;
    assign dup_blk = (status == srt_pkg::ST_DUP);
    always_comb begin
        cstat = stat;
        cstat.full = stat.full || dup_blk;
    end

    srt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_op(in_ch.data.op),
        .i_stat(cstat), .o_cmd(cmd));

    assign out_ch.data.status     = status;
    assign out_ch.data.found_key  = fkey;
    assign out_ch.data.found_slot = fslot;
endmodule

@@ src/srt_chk.sv @@
// port-level checker for the sorted ring id table, bound to the top level
// depends on the macros header
`include "sorted_ring_id_table_top_macros.svh"
module srt_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // no new item taken while a result waits
    `SRT_ASSERT_IMP(a_excl, i_clk, i_rst_n, out_valid, !in_ready)
    // accepted item is not answered in the cycle after it is taken
    `SRT_ASSERT_NEXT(a_lat, i_clk, i_rst_n, in_valid && in_ready, !out_valid)
    // result beat stays until taken
    `SRT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
endmodule

bind sorted_ring_id_table_top srt_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready));
